FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define VCW_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define VCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/vcw_pkg.sv
// shared types, constants and sample conversion for the voxel cube window
package vcw_pkg;

  localparam int DEF_MAX_X = 256;
  localparam int DEF_MAX_Y = 256;
  localparam int OUT_DEPTH = 3;
  localparam int PADDR_W   = 5;

  localparam logic [8:0]  SIZE_X_RST = 9'd256;
  localparam logic [8:0]  SIZE_Y_RST = 9'd256;
  localparam logic [15:0] SIZE_Z_RST = 16'd256;

  typedef enum logic [2:0] {
    REG_SIZE_X        = 3'd0,
    REG_SIZE_Y        = 3'd1,
    REG_SIZE_Z        = 3'd2,
    REG_SAMPLE_FORMAT = 3'd3,
    REG_SWAP_BYTES    = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    FMT_U8  = 2'd0,
    FMT_U16 = 2'd1,
    FMT_F32 = 2'd2
  } fmt_t;

  typedef struct packed {
    logic [8:0]  size_x;
    logic [8:0]  size_y;
    logic [15:0] size_z;
    logic [1:0]  sample_format;
    logic        swap_bytes;
  } cfg_t;

  typedef struct packed {
    logic [31:0] corner_a;
    logic [31:0] corner_b;
    logic [31:0] corner_c;
    logic [31:0] corner_d;
    logic [31:0] corner_e;
    logic [31:0] corner_f;
    logic [31:0] corner_g;
    logic [31:0] corner_h;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
    logic [15:0] cell_z;
    logic        last_cell;
  } cell_t;

  function automatic logic [31:0] convert_sample(input logic [31:0] raw,
                                                 input logic [1:0]  fmt,
                                                 input logic        swap);
    logic [31:0] res;
    case (fmt)
      FMT_U8:  res = {24'd0, raw[7:0]};
      FMT_U16: res = swap ? {16'd0, raw[7:0], raw[15:8]} : {16'd0, raw[15:0]};
      default: res = swap ? {raw[7:0], raw[15:8], raw[23:16], raw[31:24]} : raw;
    endcase
    return res;
  endfunction

endpackage

FILE: hw/rtl/voxel_cube_window.sv
// top level of the voxel cube window
//
// voxel samples enter on sample_valid/sample_ready in raster order: x fastest,
// then y, then slice z. each sample is cut to its format width and optionally
// byte-swapped. a sample at (x+1, y+1, z+1) completes cell (x, y, z), and one
// item with the eight corner values, cell indices and last_cell flag leaves on
// cell_valid/cell_ready; other samples produce nothing.
// a completing sample is registered in stage s1 and then in the output queue.
// throughput: one sample per cycle while sample_ready is high; the slice memory does
// a read-first access and the line memory one read and one write per cycle.
// the output queue holds three items; sample_ready drops when the queue and the
// sample in flight could fill it, so a stalled receiver stalls the input.
// reset clears the position to the volume origin and empties the queue; memory
// contents need no clearing. any register write also restarts the volume.
// configuration goes through an apb port, register i at byte address 4*i.
module voxel_cube_window #(
  parameter int MAX_X = vcw_pkg::DEF_MAX_X,
  parameter int MAX_Y = vcw_pkg::DEF_MAX_Y
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  logic [31:0]                 sample,
  output logic                        cell_valid,
  input  logic                        cell_ready,
  output logic [31:0]                 corner_a,
  output logic [31:0]                 corner_b,
  output logic [31:0]                 corner_c,
  output logic [31:0]                 corner_d,
  output logic [31:0]                 corner_e,
  output logic [31:0]                 corner_f,
  output logic [31:0]                 corner_g,
  output logic [31:0]                 corner_h,
  output logic [7:0]                  cell_x,
  output logic [7:0]                  cell_y,
  output logic [15:0]                 cell_z,
  output logic                        last_cell
);
  import vcw_pkg::*;

  localparam int CntW = $clog2(OUT_DEPTH + 1);

  cfg_t            cfg;
  logic            cfg_wr;
  logic            accept;
  logic            push;
  logic            busy;
  cell_t           cell_new;
  cell_t           cell_out;
  logic [CntW-1:0] fifo_count;

  assign pready       = 1'b1;
  assign sample_ready = ((CntW + 1)'(fifo_count) + (CntW + 1)'(busy)) <
                        (CntW + 1)'(OUT_DEPTH);
  assign accept       = sample_valid && sample_ready;

  vcw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  vcw_window #(
    .MAX_X (MAX_X),
    .MAX_Y (MAX_Y)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cfg_wr    (cfg_wr),
    .accept    (accept),
    .sample    (sample),
    .push      (push),
    .cell_data (cell_new),
    .busy      (busy)
  );

  vcw_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .cell_in   (cell_new),
    .pop_ready (cell_ready),
    .out_valid (cell_valid),
    .cell_out  (cell_out),
    .count     (fifo_count)
  );

  assign corner_a  = cell_out.corner_a;
  assign corner_b  = cell_out.corner_b;
  assign corner_c  = cell_out.corner_c;
  assign corner_d  = cell_out.corner_d;
  assign corner_e  = cell_out.corner_e;
  assign corner_f  = cell_out.corner_f;
  assign corner_g  = cell_out.corner_g;
  assign corner_h  = cell_out.corner_h;
  assign cell_x    = cell_out.cell_x;
  assign cell_y    = cell_out.cell_y;
  assign cell_z    = cell_out.cell_z;
  assign last_cell = cell_out.last_cell;

endmodule

FILE: hw/rtl/vcw_regs.sv
// apb configuration registers
module vcw_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [vcw_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output vcw_pkg::cfg_t               cfg,
  output logic                        cfg_wr
);
  import vcw_pkg::*;

  reg_idx_t idx;
  logic     wr_en;
  logic     hit;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_wr = wr_en & hit;

  always_comb begin
    hit    = 1'b1;
    prdata = 32'd0;
    unique case (idx)
      REG_SIZE_X:        prdata = {23'd0, cfg.size_x};
      REG_SIZE_Y:        prdata = {23'd0, cfg.size_y};
      REG_SIZE_Z:        prdata = {16'd0, cfg.size_z};
      REG_SAMPLE_FORMAT: prdata = {30'd0, cfg.sample_format};
      REG_SWAP_BYTES:    prdata = {31'd0, cfg.swap_bytes};
      default:           hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.size_x        <= SIZE_X_RST;
      cfg.size_y        <= SIZE_Y_RST;
      cfg.size_z        <= SIZE_Z_RST;
      cfg.sample_format <= FMT_U8;
      cfg.swap_bytes    <= 1'b0;
    end else if (wr_en) begin
      unique case (idx)
        REG_SIZE_X:        cfg.size_x <= pwdata[8:0];
        REG_SIZE_Y:        cfg.size_y <= pwdata[8:0];
        REG_SIZE_Z:        cfg.size_z <= pwdata[15:0];
        REG_SAMPLE_FORMAT: cfg.sample_format <= pwdata[1:0];
        REG_SWAP_BYTES:    cfg.swap_bytes <= pwdata[0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/vcw_window.sv
// raster position tracking, slice and line memories, cell corner assembly
module vcw_window #(
  parameter int MAX_X = vcw_pkg::DEF_MAX_X,
  parameter int MAX_Y = vcw_pkg::DEF_MAX_Y
) (
  input  logic           clk,
  input  logic           rst,
  input  vcw_pkg::cfg_t  cfg,
  input  logic           cfg_wr,
  input  logic           accept,
  input  logic [31:0]    sample,
  output logic           push,
  output vcw_pkg::cell_t cell_data,
  output logic           busy
);
  import vcw_pkg::*;
  `include "assert_macros.svh"

  localparam int XW         = $clog2(MAX_X);
  localparam int YW         = $clog2(MAX_Y);
  localparam int SXW        = $clog2(MAX_X + 1);
  localparam int SYW        = $clog2(MAX_Y + 1);
  localparam int SliceDepth = MAX_X * MAX_Y;
  localparam int AW         = $clog2(SliceDepth);

  logic [SXW-1:0] sx;
  logic [SYW-1:0] sy;
  logic [15:0]    sz;

  logic [XW-1:0]  pos_x;
  logic [YW-1:0]  pos_y;
  logic [15:0]    pos_z;
  logic [AW-1:0]  slice_addr;
  logic           x_end;
  logic           y_end;
  logic           z_end;
  logic [31:0]    v0;

  logic [31:0]    slice_mem [SliceDepth];
  logic [63:0]    line_mem  [MAX_X];
  logic [31:0]    slice_rd;
  logic [63:0]    line_rd;

  logic           s1_valid;
  logic [31:0]    s1_v;
  logic [XW-1:0]  s1_x;
  logic [YW-1:0]  s1_y;
  logic [15:0]    s1_z;
  logic           s1_emit;
  logic           s1_last;

  logic [31:0]    left_cur;
  logic [31:0]    left_prev;
  logic [31:0]    ul_cur;
  logic [31:0]    ul_prev;
  logic [15:0]    xm1;
  logic [15:0]    ym1;

  // clamp sizes
  always_comb begin
    if (cfg.size_x < 9'd2) begin
      sx = SXW'(2);
    end else if (32'(cfg.size_x) > 32'(MAX_X)) begin
      sx = SXW'(MAX_X);
    end else begin
      sx = SXW'(cfg.size_x);
    end
    if (cfg.size_y < 9'd2) begin
      sy = SYW'(2);
    end else if (32'(cfg.size_y) > 32'(MAX_Y)) begin
      sy = SYW'(MAX_Y);
    end else begin
      sy = SYW'(cfg.size_y);
    end
    sz = (cfg.size_z < 16'd2) ? 16'd2 : cfg.size_z;
  end

  assign x_end = (SXW'(pos_x) + SXW'(1)) >= sx;
  assign y_end = (SYW'(pos_y) + SYW'(1)) >= sy;
  assign z_end = (17'(pos_z) + 17'd1) >= {1'b0, sz};
  assign v0    = convert_sample(sample, cfg.sample_format, cfg.swap_bytes);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      pos_x      <= '0;
      pos_y      <= '0;
      pos_z      <= '0;
      slice_addr <= '0;
    end else if (accept) begin
      slice_addr <= (x_end && y_end) ? '0 : slice_addr + AW'(1);
      if (x_end) begin
        pos_x <= '0;
        if (y_end) begin
          pos_y <= '0;
          pos_z <= z_end ? 16'd0 : pos_z + 16'd1;
        end else begin
          pos_y <= pos_y + YW'(1);
        end
      end else begin
        pos_x <= pos_x + XW'(1);
      end
    end
  end

  // slice memory: read-first gives the previous slice at this position
  always_ff @(posedge clk) begin
    if (accept) begin
      slice_rd              <= slice_mem[slice_addr];
      slice_mem[slice_addr] <= v0;
    end
  end

  // line memory: {current, previous slice} for the row above
  always_ff @(posedge clk) begin
    if (accept) begin
      line_rd <= line_mem[pos_x];
    end
    if (s1_valid) begin
      line_mem[s1_x] <= {s1_v, slice_rd};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_v    <= v0;
      s1_x    <= pos_x;
      s1_y    <= pos_y;
      s1_z    <= pos_z;
      s1_emit <= (pos_x != '0) && (pos_y != '0) && (pos_z != '0);
      s1_last <= x_end && y_end && z_end;
    end
    if (s1_valid) begin
      left_cur  <= s1_v;
      left_prev <= slice_rd;
      ul_cur    <= line_rd[63:32];
      ul_prev   <= line_rd[31:0];
    end
  end

  assign xm1  = 16'(s1_x) - 16'd1;
  assign ym1  = 16'(s1_y) - 16'd1;
  assign push = s1_valid && s1_emit;
  assign busy = s1_valid;

  always_comb begin
    cell_data.corner_a  = ul_cur;
    cell_data.corner_b  = line_rd[63:32];
    cell_data.corner_c  = s1_v;
    cell_data.corner_d  = left_cur;
    cell_data.corner_e  = ul_prev;
    cell_data.corner_f  = line_rd[31:0];
    cell_data.corner_g  = slice_rd;
    cell_data.corner_h  = left_prev;
    cell_data.cell_x    = xm1[7:0];
    cell_data.cell_y    = ym1[7:0];
    cell_data.cell_z    = s1_z - 16'd1;
    cell_data.last_cell = s1_last;
  end

  `VCW_ASSERT_IMPL(a_line_ports_apart, clk, rst, (accept && s1_valid && !$past(cfg_wr)), (s1_x != pos_x), "line buffer read and write on the same entry")
  `VCW_ASSERT_IMPL(a_pos_x_in_row, clk, rst, 1'b1, (SXW'(pos_x) < sx), "column position beyond row length")
  `VCW_ASSERT_IMPL(a_addr_slice_start, clk, rst, ((pos_x == '0) && (pos_y == '0)), (slice_addr == '0), "slice address out of step at slice start")

endmodule

FILE: hw/rtl/vcw_out_fifo.sv
// output queue decoupling the cell window from the receiver
module vcw_out_fifo (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       push,
  input  vcw_pkg::cell_t                             cell_in,
  input  logic                                       pop_ready,
  output logic                                       out_valid,
  output vcw_pkg::cell_t                             cell_out,
  output logic [$clog2(vcw_pkg::OUT_DEPTH + 1)-1:0] count
);
  import vcw_pkg::*;
  `include "assert_macros.svh"

  localparam int PtrW = $clog2(OUT_DEPTH);
  localparam int CntW = $clog2(OUT_DEPTH + 1);

  cell_t           entries [OUT_DEPTH];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic            pop;

  assign out_valid = count != '0;
  assign pop       = out_valid && pop_ready;
  assign cell_out  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cell_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(OUT_DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (push && !pop) begin
        count <= count + CntW'(1);
      end else if (pop && !push) begin
        count <= count - CntW'(1);
      end
    end
  end

  `VCW_ASSERT_IMPL(a_no_overflow, clk, rst, push, (count < CntW'(OUT_DEPTH)), "output queue overflow")
  `VCW_ASSERT_NEXT(a_push_shows, clk, rst, (push && !pop), out_valid, "pushed cell not presented")
  `VCW_ASSERT_IMPL(a_count_in_range, clk, rst, 1'b1, (count <= CntW'(OUT_DEPTH)), "output queue count beyond depth")

endmodule

FILE: sim/voxel_cube_window_tb.sv
// testbench for voxel_cube_window: random and fixed-pattern volumes checked against a cell predictor
`timescale 1ns / 1ps

module voxel_cube_window_tb;
  import vcw_pkg::*;

  localparam int          PLANE_WORDS = DEF_MAX_X * DEF_MAX_Y;
  localparam int          HOLD_CYCLES = 400;
  localparam int          CYCLE_LIMIT = 250000;
  localparam logic [1:0]  FMT_SPARE   = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_ready;
  logic [31:0]         sample = '0;
  logic                cell_valid;
  logic                cell_ready = 1'b0;
  logic [31:0]         corner_a, corner_b, corner_c, corner_d;
  logic [31:0]         corner_e, corner_f, corner_g, corner_h;
  logic [7:0]          cell_x;
  logic [7:0]          cell_y;
  logic [15:0]         cell_z;
  logic                last_cell;

  cfg_t                shadow_cfg = '{SIZE_X_RST, SIZE_Y_RST, SIZE_Z_RST, FMT_U8, 1'b0};
  logic [31:0]         older_slice [PLANE_WORDS];
  logic [31:0]         filling_slice [PLANE_WORDS];
  int unsigned         at_x = 0;
  int unsigned         at_y = 0;
  int unsigned         at_z = 0;
  cell_t               cells_due [$];

  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;
  int                  hold_requests = 0;
  int                  hold_served = 0;
  int                  hold_left = 0;

  voxel_cube_window uut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .cell_valid   (cell_valid),
    .cell_ready   (cell_ready),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .corner_d     (corner_d),
    .corner_e     (corner_e),
    .corner_f     (corner_f),
    .corner_g     (corner_g),
    .corner_h     (corner_h),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_z       (cell_z),
    .last_cell    (last_cell)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL voxel_cube_window");
      $finish;
    end
  end

  // long receiver hold-off, started on request
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_left <= HOLD_CYCLES;
      hold_served <= hold_served + 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      cell_ready <= 1'b0;
    end else begin
      cell_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic int unsigned clamp_dim(input int unsigned raw, input int unsigned hi);
    if (raw < 2) return 2;
    if (raw > hi) return hi;
    return raw;
  endfunction

  function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] value);
    case (reg_idx_t'(idx))
      REG_SIZE_X:        shadow_cfg.size_x = value[8:0];
      REG_SIZE_Y:        shadow_cfg.size_y = value[8:0];
      REG_SIZE_Z:        shadow_cfg.size_z = value[15:0];
      REG_SAMPLE_FORMAT: shadow_cfg.sample_format = value[1:0];
      REG_SWAP_BYTES:    shadow_cfg.swap_bytes = value[0];
      default:           return;
    endcase
    at_x = 0;
    at_y = 0;
    at_z = 0;
  endfunction

  function automatic void predict_cell(input logic [31:0] raw);
    int unsigned sx, sy, sz, lo, hi, nbytes;
    logic [31:0] v;
    cell_t c;
    sx = clamp_dim(shadow_cfg.size_x, DEF_MAX_X);
    sy = clamp_dim(shadow_cfg.size_y, DEF_MAX_Y);
    sz = (shadow_cfg.size_z < 2) ? 2 : shadow_cfg.size_z;
    case (shadow_cfg.sample_format)
      FMT_U8:  nbytes = 1;
      FMT_U16: nbytes = 2;
      default: nbytes = 4;
    endcase
    v = '0;
    for (int b = 0; b < nbytes; b++) begin
      v[8*b +: 8] = shadow_cfg.swap_bytes ? raw[8*(nbytes-1-b) +: 8] : raw[8*b +: 8];
    end
    if (at_x >= 1 && at_y >= 1 && at_z >= 1) begin
      lo = (at_y - 1) * sx + at_x - 1;
      hi = at_y * sx + at_x - 1;
      c.corner_a = filling_slice[lo];
      c.corner_b = filling_slice[lo + 1];
      c.corner_c = v;
      c.corner_d = filling_slice[hi];
      c.corner_e = older_slice[lo];
      c.corner_f = older_slice[lo + 1];
      c.corner_g = older_slice[hi + 1];
      c.corner_h = older_slice[hi];
      c.cell_x = 8'(at_x - 1);
      c.cell_y = 8'(at_y - 1);
      c.cell_z = 16'(at_z - 1);
      c.last_cell = (at_x == sx - 1) && (at_y == sy - 1) && (at_z == sz - 1);
      cells_due.push_back(c);
    end
    filling_slice[at_y * sx + at_x] = v;
    if (at_x + 1 >= sx) begin
      at_x = 0;
      if (at_y + 1 >= sy) begin
        at_y = 0;
        for (int i = 0; i < sx * sy; i++) older_slice[i] = filling_slice[i];
        at_z = (at_z + 1 >= sz) ? 0 : at_z + 1;
      end else begin
        at_y = at_y + 1;
      end
    end else begin
      at_x = at_x + 1;
    end
  endfunction

  function automatic void check_field(input string what, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns mismatch %s: expected %h, got %h", $time, what, want, got);
      mismatches++;
    end
  endfunction

  function automatic void check_cell();
    cell_t want;
    cell_t got;
    got = {corner_a, corner_b, corner_c, corner_d, corner_e, corner_f, corner_g, corner_h,
           cell_x, cell_y, cell_z, last_cell};
    if (cells_due.size() == 0) begin
      $display("%0t ns unexpected cell: expected none, got %h", $time, got);
      mismatches++;
      return;
    end
    want = cells_due.pop_front();
    check_field("corner_a", want.corner_a, got.corner_a);
    check_field("corner_b", want.corner_b, got.corner_b);
    check_field("corner_c", want.corner_c, got.corner_c);
    check_field("corner_d", want.corner_d, got.corner_d);
    check_field("corner_e", want.corner_e, got.corner_e);
    check_field("corner_f", want.corner_f, got.corner_f);
    check_field("corner_g", want.corner_g, got.corner_g);
    check_field("corner_h", want.corner_h, got.corner_h);
    check_field("cell_x", 32'(want.cell_x), 32'(got.cell_x));
    check_field("cell_y", 32'(want.cell_y), 32'(got.cell_y));
    check_field("cell_z", 32'(want.cell_z), 32'(got.cell_z));
    check_field("last_cell", 32'(want.last_cell), 32'(got.last_cell));
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (psel && penable && pwrite && pready) apply_reg(paddr[4:2], pwdata);
      if (sample_valid && sample_ready) predict_cell(sample);
      if (cell_valid && cell_ready) check_cell();
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_item(input logic [31:0] word);
    if ($urandom_range(99) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= word;
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic send_random(input int count);
    repeat (count) send_item(rand_word());
  endtask

  task automatic settle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (cells_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(input logic [8:0] sx, input logic [8:0] sy, input logic [15:0] sz,
                           input logic [1:0] fmt, input logic swap);
    settle();
    write_reg(REG_SIZE_X, 32'(sx));
    write_reg(REG_SIZE_Y, 32'(sy));
    write_reg(REG_SIZE_Z, 32'(sz));
    write_reg(REG_SAMPLE_FORMAT, 32'(fmt));
    write_reg(REG_SWAP_BYTES, 32'(swap));
  endtask

  // default 256-wide volume, far too short to close a cell
  task automatic test_reset_config();
    send_random(20);
  endtask

  task automatic test_sample_formats();
    logic [31:0] pattern [8] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_00FF, 32'hFF00_FF00,
                                 32'h1234_5678, 32'h8000_0001, 32'h7FFF_FFFE, 32'hA5C3_3C5A};
    // sizes below the minimum clamp to a single 2x2x2 cell; swap is moot for bytes
    configure(9'd0, 9'd1, 16'd0, FMT_U8, 1'b1);
    foreach (pattern[i]) send_item(pattern[i]);
    configure(9'd2, 9'd2, 16'd2, FMT_U16, 1'b1);
    foreach (pattern[i]) send_item(pattern[7 - i]);
    configure(9'd2, 9'd2, 16'd2, FMT_F32, 1'b1);
    foreach (pattern[i]) send_item(pattern[i] ^ 32'h0F0F_F0F0);
  endtask

  // row width above the limit clamps to 256
  task automatic test_wide_row();
    configure(9'd300, 9'd2, 16'd2, FMT_U16, 1'b0);
    send_random(256 * 2 * 2);
  endtask

  task automatic test_tall_slice();
    configure(9'd2, 9'd64, 16'd2, FMT_SPARE, 1'b1);
    send_random(2 * 64 * 2);
  endtask

  // deepest volume, abandoned part way by the next register write
  task automatic test_deep_volume();
    configure(9'd3, 9'd3, 16'hFFFF, FMT_F32, 1'b0);
    send_random(40);
  endtask

  task automatic test_random_volumes(input int budget);
    int sent;
    int unsigned sx, sy, sz, vol, total;
    logic [8:0] rx, ry;
    logic [15:0] rz;
    sent = 0;
    while (sent < budget) begin
      rx = ($urandom_range(9) == 0) ? 9'($urandom_range(1)) : 9'($urandom_range(6, 2));
      ry = ($urandom_range(9) == 0) ? 9'($urandom_range(1)) : 9'($urandom_range(6, 2));
      rz = ($urandom_range(9) == 0) ? 16'($urandom_range(1)) : 16'($urandom_range(4, 2));
      configure(rx, ry, rz, 2'($urandom_range(3)), 1'($urandom_range(1)));
      sx = clamp_dim(rx, DEF_MAX_X);
      sy = clamp_dim(ry, DEF_MAX_Y);
      sz = clamp_dim(rz, 16'hFFFF);
      vol = sx * sy * sz;
      total = vol * $urandom_range(2, 1);
      if ($urandom_range(3) == 0) total += $urandom_range(vol - 1, 1);
      send_random(total);
      sent += total;
    end
  endtask

  task automatic test_backpressure();
    configure(9'd6, 9'd6, 16'd3, FMT_U16, 1'b0);
    hold_requests <= hold_requests + 1;
    send_random(6 * 6 * 3);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_idle_pct <= 7;
    recv_idle_pct <= 70;
    test_reset_config();
    test_sample_formats();
    test_wide_row();
    test_random_volumes(25);

    settle();
    send_idle_pct <= 70;
    recv_idle_pct <= 7;
    test_tall_slice();
    test_deep_volume();
    test_random_volumes(25);

    settle();
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    test_backpressure();
    test_random_volumes(25);

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS voxel_cube_window");
    end else begin
      $display("FAIL voxel_cube_window");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/vcw_pkg.sv
hw/rtl/vcw_regs.sv
hw/rtl/vcw_window.sv
hw/rtl/vcw_out_fifo.sv
hw/rtl/voxel_cube_window.sv
sim/voxel_cube_window_tb.sv
